// ----- design/xsrr_pkg.sv -----
// types and constants shared by the xorshift128+ random range block
// no dependencies

package xsrr_pkg;

  localparam int WORD_W = 64;
  localparam int VAL_W  = 32;
  localparam int SPAN_W = VAL_W + 1;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam int SHIFT_A = 23;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 26;

  localparam logic [VAL_W-1:0] SEED_RESET = 32'd1;

  // request kinds; the unused code behaves as a raw word request
  localparam logic [1:0] OP_RAW   = 2'd0;
  localparam logic [1:0] OP_COIN  = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] range_low;
    logic signed [VAL_W-1:0] range_high;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]       random_word;
    logic                    coin;
    logic signed [VAL_W-1:0] ranged_value;
    logic                    bad_range;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- design/xorshift128p_random_range.sv -----
// xorshift128+ random source with raw word, coin flip and ranged integer requests
// depends on xsrr_pkg

// Each accepted item advances the xorshift128+ state once, in the cycle it is
// accepted, and yields exactly one result item. Raw word and coin flip requests
// (and the unused opcode) go straight to the done state, which loads the result
// once the output register is free. A ranged request with range_high >= range_low
// first runs the divide state: the remainder of the 64-bit word by the 33-bit span
// is formed by one shared compare-and-subtract unit, one word bit per cycle, and
// range_low is added on load. An inverted range flags bad_range, returns range_low.
// The block takes a new item only when idle; a result waits in the output
// register while the next item is accepted. Writing seed_data (seed_write high)
// loads the state with zero and the seed; it must be done while the block is idle.
// After reset the state is as if the seed 1 had been written.

module xorshift128p_random_range (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xsrr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output xsrr_pkg::rsp_t rsp,
  input  logic          seed_write,
  input  logic [31:0]   seed_data
);
  import xsrr_pkg::*;

  state_t                  state, state_next;
  logic [WORD_W-1:0]       sa, sb;
  logic [WORD_W-1:0]       word;
  logic [1:0]              op;
  logic signed [VAL_W-1:0] lo;
  logic                    bad;
  logic [SPAN_W-1:0]       span;
  logic [SPAN_W-1:0]       rem;
  logic [CNT_W-1:0]        cnt;

  logic                    accept;
  logic                    rsp_load;
  logic [WORD_W-1:0]       x_mix, b_next, word_next;
  logic                    in_bad;
  logic [SPAN_W-1:0]       in_span;
  logic [SPAN_W:0]         trial;
  logic                    trial_ge;
  logic [SPAN_W-1:0]       rem_next;
  rsp_t                    rsp_next;

  // generator step on the current state
  always_comb begin
    x_mix     = sa ^ (sa << SHIFT_A);
    b_next    = x_mix ^ sb ^ (x_mix >> SHIFT_B) ^ (sb >> SHIFT_C);
    word_next = b_next + sb;
  end

  // range check and span at 33 bits
  always_comb begin
    in_bad  = (req.range_high < req.range_low);
    in_span = {req.range_high[VAL_W-1], req.range_high}
            - {req.range_low[VAL_W-1], req.range_low} + SPAN_W'(1);
  end

  // shared compare-and-subtract unit: one remainder bit per cycle
  always_comb begin
    trial    = {rem, word[cnt]};
    trial_ge = (trial >= {1'b0, span});
    rem_next = trial_ge ? SPAN_W'(trial - {1'b0, span}) : trial[SPAN_W-1:0];
  end

  // result assembly
  always_comb begin
    rsp_next.random_word  = word;
    rsp_next.coin         = word[0];
    rsp_next.ranged_value = '0;
    rsp_next.bad_range    = 1'b0;
    if (op == OP_RANGE) begin
      rsp_next.bad_range    = bad;
      rsp_next.ranged_value = bad ? lo : VAL_W'(lo + rem[VAL_W-1:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.opcode == OP_RANGE && !in_bad) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_stall = (state != ST_IDLE);
    accept    = req_valid && (state == ST_IDLE);
    rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // generator state, seeded by reset or a seed write
  always_ff @(posedge clk) begin
    if (rst) begin
      sa <= '0;
      sb <= WORD_W'(SEED_RESET);
    end else if (seed_write) begin
      sa <= '0;
      sb <= WORD_W'(seed_data);
    end else if (accept) begin
      sa <= sb;
      sb <= b_next;
    end
  end

  // item payload and remainder datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      word <= word_next;
      op   <= req.opcode;
      lo   <= req.range_low;
      bad  <= in_bad;
      span <= in_span;
      rem  <= '0;
      cnt  <= '1;
    end else if (state == ST_DIV) begin
      rem <= rem_next;
      cnt <= cnt - CNT_W'(1);
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  // remainder always stays below the span while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < span)
    else $error("remainder reached span");

  // only a valid ranged request enters the divide loop
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    accept && !(req.opcode == OP_RANGE && !in_bad) |=> state == ST_DONE)
    else $error("non-divide item did not go straight to done");

  // divide loop always starts at the top word bit
  a_cnt_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> cnt == '1 && rem == '0)
    else $error("divide loop not initialized");

  // a loaded result marks the output valid
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp_valid && state == ST_IDLE)
    else $error("result load lost");
`endif

endmodule

// ----- tb/xsrr_draw_checker.sv -----
// checker for the xorshift128+ random range block: watches both channels and the seed port
// predicts each result item from its own generator state and compares field by field
// depends on xsrr_pkg

`timescale 1ns / 1ps

module xsrr_draw_checker
  import xsrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        seed_write,
  input  logic [31:0] seed_data,
  output int          pending,
  output int          errors
);

  // generator state as the block should hold it
  logic [WORD_W-1:0] xs_s0;
  logic [WORD_W-1:0] xs_s1;

  // draws predicted for accepted items, oldest first
  rsp_t draws_due[$];

  int due_count  = 0;
  int miss_count = 0;

  assign pending = due_count;
  assign errors  = miss_count;

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    miss_count = miss_count + 1;
  endtask

  // advance the generator once and form the result item for this request
  function automatic rsp_t next_draw(input req_t item);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] rem;
    int                lo;
    int                hi;
    rsp_t              draw;
    x = xs_s0;
    y = xs_s1;
    xs_s0 = y;
    x = x ^ (x << SHIFT_A);
    xs_s1 = x ^ y ^ (x >> SHIFT_B) ^ (y >> SHIFT_C);
    word = xs_s1 + y;
    draw = '0;
    draw.random_word = word;
    draw.coin = word[0];
    if (item.opcode == OP_RANGE) begin
      lo = item.range_low;
      hi = item.range_high;
      if (hi < lo) begin
        // inverted bounds give the low bound back
        draw.bad_range = 1'b1;
        draw.ranged_value = lo;
      end else begin
        // span is up to 2^32, so work it out at 64 bits
        span = longint'(hi) - longint'(lo) + 64'd1;
        rem = word % span;
        draw.ranged_value = lo + rem[31:0];
      end
    end
    return draw;
  endfunction

  // per-edge tracking: results out first, then seed load, then new requests
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      xs_s0 = '0;
      xs_s1 = {32'd0, SEED_RESET};
      draws_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (draws_due.size() == 0) begin
          report_error("result item with no request pending", rsp.random_word, '0);
        end else begin
          want = draws_due.pop_front();
          if (rsp.random_word !== want.random_word)
            report_error("random_word", rsp.random_word, want.random_word);
          if (rsp.coin !== want.coin)
            report_error("coin", 64'(rsp.coin), 64'(want.coin));
          if (rsp.ranged_value !== want.ranged_value)
            report_error("ranged_value", {32'd0, rsp.ranged_value},
                         {32'd0, want.ranged_value});
          if (rsp.bad_range !== want.bad_range)
            report_error("bad_range", 64'(rsp.bad_range), 64'(want.bad_range));
        end
      end
      if (seed_write) begin
        xs_s0 = '0;
        xs_s1 = {32'd0, seed_data};
      end
      if (req_valid && !req_stall) begin
        draws_due.push_back(next_draw(req));
      end
    end
    due_count <= draws_due.size();
  end

endmodule

// ----- tb/xorshift128p_random_range_test.sv -----
// top of the xorshift128+ random range testbench: clock, reset, stimulus and verdict
// depends on xsrr_pkg, xorshift128p_random_range and xsrr_draw_checker

`timescale 1ns / 1ps

module xorshift128p_random_range_test;
  import xsrr_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int VAL_MAX = 32'h7FFF_FFFF;
  localparam int VAL_MIN = int'(32'h8000_0000);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        seed_write = 1'b0;
  logic [31:0] seed_data = '0;

  int pending;
  int errors;
  int sent_count = 0;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  xorshift128p_random_range dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .seed_write (seed_write),
    .seed_data  (seed_data)
  );

  xsrr_draw_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .seed_write (seed_write),
    .seed_data  (seed_data),
    .pending    (pending),
    .errors     (errors)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // offer one item after a random gap and wait until it is taken
  task automatic offer(input logic [1:0] op, input int lo, input int hi);
    req_t item;
    int   gap;
    item.opcode = op;
    item.range_low = lo;
    item.range_high = hi;
    gap = (sent_count % 160 >= 130) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  // stop offering until every outstanding item has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    seed_data <= value;
    seed_write <= 1'b1;
    @(posedge clk);
    seed_write <= 1'b0;
  endtask

  // random bounds: wide, narrow, corner values, power-of-two spans, near zero
  task automatic pick_bounds(output int lo, output int hi);
    int     corner_vals[5];
    longint upper;
    int     k;
    corner_vals = '{VAL_MIN, VAL_MAX, -1, 0, 1};
    case ($urandom_range(0, 4))
      0: begin
        lo = $urandom;
        hi = $urandom;
      end
      1: begin
        lo = $urandom;
        upper = longint'(lo) + $urandom_range(0, 1000);
        hi = (upper > VAL_MAX) ? VAL_MAX : int'(upper);
      end
      2: begin
        lo = corner_vals[$urandom_range(0, 4)];
        hi = corner_vals[$urandom_range(0, 4)];
      end
      3: begin
        k = $urandom_range(1, 32);
        lo = ($urandom_range(0, 3) == 0) ? VAL_MIN : int'($urandom_range(0, 2000)) - 1000;
        upper = longint'(lo) + (longint'(1) << k) - 1;
        hi = (upper > VAL_MAX) ? VAL_MAX : int'(upper);
      end
      default: begin
        lo = int'($urandom_range(0, 200)) - 100;
        hi = int'($urandom_range(0, 200)) - 100;
      end
    endcase
  endtask

  // result side: random stalls, bursts with none, and two long hold-offs
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      if (taken == 400 || taken == 1300) begin
        hold = 300;
      end else if (taken % 170 >= 140) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 4);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int         lo;
    int         hi;
    int         pick;
    logic [1:0] op;
    logic [31:0] seed;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed items from the reset seed
    offer(OP_RAW, 0, 0);
    offer(OP_COIN, 0, 0);
    offer(OP_SPARE, $urandom, $urandom);
    offer(OP_RANGE, VAL_MIN, VAL_MAX);
    offer(OP_RANGE, VAL_MIN, VAL_MIN);
    offer(OP_RANGE, VAL_MAX, VAL_MAX);
    offer(OP_RANGE, VAL_MAX, VAL_MIN);
    offer(OP_RANGE, 0, -1);
    offer(OP_RANGE, -1, 0);
    offer(OP_RANGE, 0, 1);
    offer(OP_RANGE, VAL_MIN, -1);
    offer(OP_RANGE, 0, VAL_MAX);
    offer(OP_RANGE, -100, 100);
    offer(OP_COIN, VAL_MAX, VAL_MIN);
    offer(OP_RAW, -1, -1);

    // zero seed: the generator sticks at zero
    drain_results();
    write_seed(32'd0);
    offer(OP_RAW, 0, 0);
    offer(OP_COIN, 0, 0);
    offer(OP_RANGE, VAL_MIN, VAL_MAX);
    offer(OP_RANGE, 5, -5);
    offer(OP_SPARE, -1, VAL_MAX);

    // largest seed
    drain_results();
    write_seed(32'hFFFF_FFFF);
    offer(OP_RANGE, VAL_MIN, VAL_MAX);
    offer(OP_RAW, 0, 0);
    offer(OP_COIN, 0, 0);
    offer(OP_RANGE, -7, 7);
    offer(OP_SPARE, VAL_MIN, VAL_MIN);

    // random phases, each started by a seed write
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase == 2) begin
        seed = 32'hFFFF_FFFF;
      end else if (phase == 5) begin
        seed = SEED_RESET;
      end else begin
        seed = $urandom;
      end
      write_seed(seed);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          op = OP_RAW;
        end else if (pick < 4) begin
          op = OP_COIN;
        end else if (pick == 4) begin
          op = OP_SPARE;
        end else begin
          op = OP_RANGE;
        end
        pick_bounds(lo, hi);
        offer(op, lo, hi);
        // now and then let everything come back before going on
        if ($urandom_range(0, 59) == 0) drain_results();
      end
    end

    drain_results();
    repeat (70) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
